// ===== design/sliding_window_background_threshold_top_assert.svh =====
// Assertion helpers used by the top module to check itself.
`ifndef SLIDING_WINDOW_BACKGROUND_THRESHOLD_TOP_ASSERT_SVH
`define SLIDING_WINDOW_BACKGROUND_THRESHOLD_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWBT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swbt check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWBT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swbt check failed");

`endif

// ===== design/swbt_pkg.sv =====
package swbt_pkg;

	localparam int MAX_WINDOW  = 16;
	localparam int MAX_SAMPLES = 16384;
	localparam int SAMPLE_BITS = 16;

	// Configuration field widths.
	localparam int FRAMES_W = 5;
	localparam int SPF_W    = 15;
	localparam int THR_W    = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPF    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;

	localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd16;
	localparam logic [SPF_W-1:0]    SPF_RESET    = 15'd16384;
	localparam logic [THR_W-1:0]    THR_RESET    = 8'd48;

	localparam int POS_W      = $clog2(MAX_SAMPLES);
	localparam int SLOT_W     = $clog2(MAX_WINDOW);
	localparam int WADDR_W    = SLOT_W + POS_W;
	localparam int WIN_DEPTH  = MAX_WINDOW * MAX_SAMPLES;

	// Arithmetic widths, all sized for the largest window.
	localparam int SQR_W      = 2 * SAMPLE_BITS;
	localparam int SUM_W      = SAMPLE_BITS + SLOT_W;
	localparam int SQ_W       = SQR_W + SLOT_W;
	localparam int SUMS_W     = SUM_W + SQ_W;
	localparam int NSQ_W      = SQ_W + SLOT_W;
	localparam int DD_W       = 2 * SUM_W;
	localparam int QSCALE_SH  = THR_W;
	localparam int LEFT_W     = DD_W + SLOT_W + QSCALE_SH;
	localparam int TSQ_W      = 2 * THR_W;
	localparam int TN_W       = TSQ_W + FRAMES_W;
	localparam int VAR_LO_W   = 24;
	localparam int VAR_HI_W   = NSQ_W - VAR_LO_W;
	localparam int PLO_W      = TN_W + VAR_LO_W;
	localparam int PHI_W      = TN_W + VAR_HI_W;
	localparam int RIGHT_W    = TN_W + NSQ_W;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             first;
		logic             full;
		logic             last;
	} item_ctl_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] x;
		logic [SUM_W-1:0]       sum;
		logic [SQ_W-1:0]        sq;
		logic                   full;
		logic                   last;
	} stat_t;

	typedef struct packed {
		logic foreground;
		logic window_full;
		logic last_of_frame;
	} result_t;

endpackage

// ===== design/swbt_if.sv =====
interface swbt_echo_if;
	import swbt_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] intensity;
	modport source (output valid, output intensity, input ready);
	modport sink (input valid, input intensity, output ready);
endinterface

interface swbt_mask_if;
	logic valid;
	logic ready;
	logic foreground;
	logic window_full;
	logic last_of_frame;
	modport source (output valid, output foreground, output window_full,
		output last_of_frame, input ready);
	modport sink (input valid, input foreground, input window_full,
		input last_of_frame, output ready);
endinterface

interface swbt_cfg_if;
	import swbt_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/swbt_ctrl.sv =====
module swbt_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	swbt_cfg_if.sink                       cfg,
	input  logic                           accept,
	output swbt_pkg::item_ctl_t            ctl,
	output logic [swbt_pkg::WADDR_W-1:0]   win_addr,
	output logic [swbt_pkg::FRAMES_W-1:0]  n_eff,
	output logic [swbt_pkg::TN_W-1:0]      tn
);
	import swbt_pkg::*;

	logic [FRAMES_W-1:0] frames_q;
	logic [SPF_W-1:0]    spf_q;
	logic [THR_W-1:0]    thr_q;
	logic [POS_W-1:0]    pos_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [FRAMES_W-1:0] filled_q;
	logic [TSQ_W-1:0]    tsq_q;
	logic [TN_W-1:0]     tn_q;

	logic [SPF_W-1:0]    spf_eff;
	logic [SPF_W-1:0]    pos_inc;
	logic [FRAMES_W-1:0] slot_inc;
	logic                last;
	logic                restart;

	assign cfg.ready = 1'b1;

	always_comb begin
		if (frames_q < FRAMES_W'(2)) begin
			n_eff = FRAMES_W'(2);
		end else if (frames_q > FRAMES_W'(MAX_WINDOW)) begin
			n_eff = FRAMES_W'(MAX_WINDOW);
		end else begin
			n_eff = frames_q;
		end
		if (spf_q == '0) begin
			spf_eff = SPF_W'(1);
		end else if (spf_q > SPF_W'(MAX_SAMPLES)) begin
			spf_eff = SPF_W'(MAX_SAMPLES);
		end else begin
			spf_eff = spf_q;
		end
	end

	assign pos_inc  = SPF_W'(pos_q) + SPF_W'(1);
	assign slot_inc = FRAMES_W'(slot_q) + FRAMES_W'(1);
	assign last     = pos_inc >= spf_eff;
	assign restart  = cfg.valid && (cfg.index == REG_FRAMES || cfg.index == REG_SPF);

	assign ctl.pos   = pos_q;
	assign ctl.first = filled_q == '0;
	assign ctl.full  = filled_q >= n_eff;
	assign ctl.last  = last;
	assign win_addr  = {slot_q, pos_q};
	assign tn        = tn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
			spf_q    <= SPF_RESET;
			thr_q    <= THR_RESET;
			pos_q    <= '0;
			slot_q   <= '0;
			filled_q <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_FRAMES: frames_q <= cfg.data[FRAMES_W-1:0];
					REG_SPF:    spf_q    <= cfg.data[SPF_W-1:0];
					REG_THRESH: thr_q    <= cfg.data[THR_W-1:0];
					default: ;
				endcase
			end
			if (restart) begin
				pos_q    <= '0;
				slot_q   <= '0;
				filled_q <= '0;
			end else if (accept) begin
				if (last) begin
					pos_q  <= '0;
					slot_q <= (slot_inc >= n_eff) ? '0 : slot_inc[SLOT_W-1:0];
					if (filled_q < n_eff) begin
						filled_q <= filled_q + FRAMES_W'(1);
					end
				end else begin
					pos_q <= pos_inc[POS_W-1:0];
				end
			end
		end
	end

	// T^2*N settles via tsq_q then tn_q after a write, long before items reach the test.
	always_ff @(posedge clk) begin
		tsq_q <= TSQ_W'(thr_q) * TSQ_W'(thr_q);
		tn_q  <= TN_W'(tsq_q) * TN_W'(n_eff);
	end

endmodule

// ===== design/swbt_update.sv =====
module swbt_update (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [swbt_pkg::SAMPLE_BITS-1:0]  intensity,
	input  swbt_pkg::item_ctl_t               ctl,
	input  logic [swbt_pkg::WADDR_W-1:0]      win_addr,
	output logic                              stat_valid,
	output swbt_pkg::stat_t                   stat
);
	import swbt_pkg::*;

	logic [SAMPLE_BITS-1:0] win_mem [WIN_DEPTH];
	logic [SUMS_W-1:0]      sums_mem [MAX_SAMPLES];

	logic                   v_s1, v_s2, v_s3, v_s4;
	item_ctl_t              ctl_s1, ctl_s2;
	logic [SAMPLE_BITS-1:0] x_s1, x_s2, x_s3;
	logic [SAMPLE_BITS-1:0] old_s1, old_s2;
	logic [SUMS_W-1:0]      rd_s1, rd_s2;
	logic [SQR_W-1:0]       xsq_s2, oldsq_s2;
	logic [POS_W-1:0]       pos_s3, pos_s4;
	logic [SUM_W-1:0]       sum_s3, sum_s4;
	logic [SQ_W-1:0]        sq_s3, sq_s4;
	logic                   full_s3, last_s3;

	logic [SUM_W-1:0]       base_sum, sum_new;
	logic [SQ_W-1:0]        base_sq, sq_new;

	// Read-first: the slot being replaced comes out while the new sample goes in.
	always_ff @(posedge clk) begin
		if (accept) begin
			old_s1            <= win_mem[win_addr];
			win_mem[win_addr] <= intensity;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= sums_mem[ctl.pos];
		end
		if (v_s2) begin
			sums_mem[ctl_s2.pos] <= {sum_new, sq_new};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1   <= ctl;
		x_s1     <= intensity;
		ctl_s2   <= ctl_s1;
		x_s2     <= x_s1;
		old_s2   <= old_s1;
		rd_s2    <= rd_s1;
		xsq_s2   <= SQR_W'(x_s1) * SQR_W'(x_s1);
		oldsq_s2 <= SQR_W'(old_s1) * SQR_W'(old_s1);
		pos_s3   <= ctl_s2.pos;
		sum_s3   <= sum_new;
		sq_s3    <= sq_new;
		x_s3     <= x_s2;
		full_s3  <= ctl_s2.full;
		last_s3  <= ctl_s2.last;
		pos_s4   <= pos_s3;
		sum_s4   <= sum_s3;
		sq_s4    <= sq_s3;
	end

	// The memory copy may miss the two most recent writes: one landed after the read
	// and one on the same edge. Those two come from the stage registers instead.
	always_comb begin
		if (v_s3 && pos_s3 == ctl_s2.pos) begin
			base_sum = sum_s3;
			base_sq  = sq_s3;
		end else if (v_s4 && pos_s4 == ctl_s2.pos) begin
			base_sum = sum_s4;
			base_sq  = sq_s4;
		end else begin
			base_sum = rd_s2[SUMS_W-1:SQ_W];
			base_sq  = rd_s2[SQ_W-1:0];
		end

		if (ctl_s2.first) begin
			sum_new = SUM_W'(x_s2);
			sq_new  = SQ_W'(xsq_s2);
		end else if (ctl_s2.full) begin
			sum_new = base_sum - SUM_W'(old_s2) + SUM_W'(x_s2);
			sq_new  = base_sq - SQ_W'(oldsq_s2) + SQ_W'(xsq_s2);
		end else begin
			sum_new = base_sum + SUM_W'(x_s2);
			sq_new  = base_sq + SQ_W'(xsq_s2);
		end
	end

	assign stat_valid = v_s3;
	assign stat.x     = x_s3;
	assign stat.sum   = sum_s3;
	assign stat.sq    = sq_s3;
	assign stat.full  = full_s3;
	assign stat.last  = last_s3;

endmodule

// ===== design/swbt_test.sv =====
module swbt_test (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             stat_valid,
	input  swbt_pkg::stat_t                  stat,
	input  logic [swbt_pkg::FRAMES_W-1:0]    n_eff,
	input  logic [swbt_pkg::TN_W-1:0]        tn,
	output logic                             res_valid,
	output swbt_pkg::result_t                res
);
	import swbt_pkg::*;

	logic                v_s4, v_s5, v_s6;
	logic                dpos_s4, cand_s5, cand_s6;
	logic                full_s4, full_s5, full_s6;
	logic                last_s4, last_s5, last_s6;
	logic [SUM_W-1:0]    d_s4;
	logic [NSQ_W-1:0]    nsq_s4, ssq_s4;
	logic [DD_W-1:0]     dd_s5;
	logic [NSQ_W-1:0]    spread_s5;
	logic [LEFT_W-1:0]   left_s6;
	logic [PLO_W-1:0]    plo_s6;
	logic [PHI_W-1:0]    phi_s6;

	logic [SUM_W-1:0]    nx;
	logic [SLOT_W-1:0]   nm1;
	logic [RIGHT_W-1:0]  right;

	assign nx  = SUM_W'(n_eff) * SUM_W'(stat.x);
	assign nm1 = SLOT_W'(n_eff - FRAMES_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s4 <= stat_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		dpos_s4   <= nx > stat.sum;
		d_s4      <= nx - stat.sum;
		nsq_s4    <= NSQ_W'(n_eff) * NSQ_W'(stat.sq);
		ssq_s4    <= NSQ_W'(stat.sum) * NSQ_W'(stat.sum);
		full_s4   <= stat.full;
		last_s4   <= stat.last;

		dd_s5     <= DD_W'(d_s4) * DD_W'(d_s4);
		spread_s5 <= (nsq_s4 > ssq_s4) ? nsq_s4 - ssq_s4 : '0;
		cand_s5   <= dpos_s4 && full_s4;
		full_s5   <= full_s4;
		last_s5   <= last_s4;

		// Right side T^2*N*spread is split in two partial products, joined next stage.
		left_s6   <= (LEFT_W'(nm1) * LEFT_W'(dd_s5)) << QSCALE_SH;
		plo_s6    <= PLO_W'(tn) * PLO_W'(spread_s5[VAR_LO_W-1:0]);
		phi_s6    <= PHI_W'(tn) * PHI_W'(spread_s5[NSQ_W-1:VAR_LO_W]);
		cand_s6   <= cand_s5;
		full_s6   <= full_s5;
		last_s6   <= last_s5;
	end

	assign right = RIGHT_W'(plo_s6) + (RIGHT_W'(phi_s6) << VAR_LO_W);

	assign res_valid         = v_s6;
	assign res.foreground    = cand_s6 && (RIGHT_W'(left_s6) > right);
	assign res.window_full   = full_s6;
	assign res.last_of_frame = last_s6;

endmodule

// ===== design/swbt_fifo.sv =====
module swbt_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  swbt_pkg::result_t   push_data,
	input  logic                pop,
	output logic                not_empty,
	output swbt_pkg::result_t   head
);
	import swbt_pkg::*;

	result_t               entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [CREDIT_W-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CREDIT_W'(1);
				2'b01:   cnt_q <= cnt_q - CREDIT_W'(1);
				default: ;
			endcase
		end
	end

	assign not_empty = cnt_q != '0;
	assign head      = entry_q[rd_q];

endmodule

// ===== design/sliding_window_background_threshold_top.sv =====
// Channel  Dir  Payload                                   Notes
// echo     in   intensity[15:0]                           one sample per request, raster order
// mask     out  foreground, window_full, last_of_frame    one result per sample, in order
// cfg      in   index[1:0], data[14:0]                    register write, always ready
//
// Throughput is one sample per cycle while echo.ready is high; results pass the update
// and test stages and the result queue to mask. The per-position sums live in one memory
// that is read at accept and written back two stages later, with the two newest writes
// forwarded. Reset clears the registers and counters only; memories are not cleared and
// no clearing pass runs. A stalled mask channel fills an 8-entry result queue while the
// pipeline keeps moving; echo.ready drops once eight requests are outstanding.
`include "sliding_window_background_threshold_top_assert.svh"

module sliding_window_background_threshold_top (
	input  logic         clk,
	input  logic         arst_n,
	swbt_echo_if.sink    echo,
	swbt_mask_if.source  mask,
	swbt_cfg_if.sink     cfg
);
	import swbt_pkg::*;

	logic                accept;
	logic                pop;
	logic [CREDIT_W-1:0] credit_q;
	item_ctl_t           ctl;
	logic [WADDR_W-1:0]  win_addr;
	logic [FRAMES_W-1:0] n_eff;
	logic [TN_W-1:0]     tn;
	logic                stat_valid;
	stat_t               stat;
	logic                res_valid;
	result_t             res;
	logic                fifo_ne;
	result_t             fifo_head;

	assign echo.ready = credit_q < CREDIT_W'(FIFO_DEPTH);
	assign accept     = echo.valid && echo.ready;
	assign pop        = mask.valid && mask.ready;

	// Every accepted sample holds a queue entry until its result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({accept, pop})
				2'b10:   credit_q <= credit_q + CREDIT_W'(1);
				2'b01:   credit_q <= credit_q - CREDIT_W'(1);
				default: ;
			endcase
		end
	end

	swbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.accept   (accept),
		.ctl      (ctl),
		.win_addr (win_addr),
		.n_eff    (n_eff),
		.tn       (tn)
	);

	swbt_update u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.intensity  (echo.intensity),
		.ctl        (ctl),
		.win_addr   (win_addr),
		.stat_valid (stat_valid),
		.stat       (stat)
	);

	swbt_test u_test (
		.clk        (clk),
		.arst_n     (arst_n),
		.stat_valid (stat_valid),
		.stat       (stat),
		.n_eff      (n_eff),
		.tn         (tn),
		.res_valid  (res_valid),
		.res        (res)
	);

	swbt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (pop),
		.not_empty (fifo_ne),
		.head      (fifo_head)
	);

	assign mask.valid         = fifo_ne;
	assign mask.foreground    = fifo_head.foreground;
	assign mask.window_full   = fifo_head.window_full;
	assign mask.last_of_frame = fifo_head.last_of_frame;

	`SWBT_ASSERT_NOW(a_credit_bound, 1'b1, credit_q <= CREDIT_W'(FIFO_DEPTH))
	`SWBT_ASSERT_NOW(a_result_owned, res_valid, credit_q != '0)
	`SWBT_ASSERT_NOW(a_output_owned, mask.valid, credit_q != '0)
	`SWBT_ASSERT_NEXT(a_accept_counted, accept, credit_q != '0)

endmodule
